### rtl/urx_pkg.sv
// ----------------------------------------------------------------------------
// urx_pkg
// Shared types, register map, request codes and interrupt helpers for the
// UART register block with receive FIFO.
// ----------------------------------------------------------------------------
package urx_pkg;

  localparam int RX_DEPTH = 16;
  localparam int PTR_W    = $clog2(RX_DEPTH);
  localparam int CNT_W    = $clog2(RX_DEPTH + 1);
  localparam int LVL_W    = 9;
  localparam int CMP_W    = (CNT_W > LVL_W) ? CNT_W : LVL_W;

  // Request codes
  localparam logic [2:0] REQ_READ    = 3'd0;
  localparam logic [2:0] REQ_WRITE   = 3'd1;
  localparam logic [2:0] REQ_RX_BYTE = 3'd2;
  localparam logic [2:0] REQ_BREAK   = 3'd3;
  localparam logic [2:0] REQ_TIMEOUT = 3'd4;

  // Register word indexes
  localparam logic [3:0] R_ULCON = 4'd0;
  localparam logic [3:0] R_UCON  = 4'd1;
  localparam logic [3:0] R_UFCON = 4'd2;
  localparam logic [3:0] R_UMCON = 4'd3;
  localparam logic [3:0] R_STAT  = 4'd4;
  localparam logic [3:0] R_ERR   = 4'd5;
  localparam logic [3:0] R_FSTAT = 4'd6;
  localparam logic [3:0] R_MSTAT = 4'd7;
  localparam logic [3:0] R_TX    = 4'd8;
  localparam logic [3:0] R_RX    = 4'd9;
  localparam logic [3:0] R_BRDIV = 4'd10;
  localparam logic [3:0] R_FRAC  = 4'd11;
  localparam logic [3:0] R_INTP  = 4'd12;
  localparam logic [3:0] R_INTSP = 4'd13;
  localparam logic [3:0] R_INTM  = 4'd14;

  // Interrupt source bits
  localparam logic [2:0] SRC_RXD = 3'b001;
  localparam logic [2:0] SRC_ERR = 3'b010;
  localparam logic [2:0] SRC_TXD = 3'b100;

  localparam logic [31:0] UCON_RESET  = 32'h0000_3000;
  localparam logic [31:0] FSTAT_FULL  = 32'h0000_0100;
  localparam logic [31:0] UFCON_SELFCLR = 32'h0000_0006;
  localparam logic [1:0]  UCON_RX_DMA = 2'b10;
  localparam int          UCON_TOUT_EN = 11;
  localparam int          UCON_TOUT_DIS = 7;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } urx_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_line;
    logic        dma_busy;
  } urx_out_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] wdata;
  } urx_fifo_ctrl_t;

  typedef struct packed {
    logic [2:0] intsp;
    logic [2:0] intp;
    logic       dma_hit;
  } urx_irq_t;

  // Trigger level scaled by channel: 32, 8, 2 or 0
  function automatic logic [LVL_W-1:0] level_scale(input logic [2:0] chan,
                                                   input logic [3:0] v);
    logic [LVL_W-1:0] r;
    case (chan)
      3'd0:       r = {v, 5'b0};
      3'd1, 3'd4: r = LVL_W'({v, 3'b0});
      3'd2, 3'd3: r = LVL_W'({v, 1'b0});
      default:    r = '0;
    endcase
    return r;
  endfunction

  function automatic urx_irq_t irq_eval(input logic             fifo_en,
                                        input logic [2:0]       rx_trig,
                                        input logic [2:0]       chan,
                                        input logic             tout_dis,
                                        input logic             stat0,
                                        input logic [CNT_W-1:0] cnt,
                                        input logic [2:0]       intsp,
                                        input logic [2:0]       intm);
    urx_irq_t         r;
    logic [CMP_W-1:0] lvl;
    logic             rx_hit;
    r.intsp   = intsp;
    r.dma_hit = 1'b0;
    lvl       = CMP_W'(level_scale(chan, {1'b0, rx_trig} + 4'd1));
    rx_hit    = ((cnt != '0) && !tout_dis) || (CMP_W'(cnt) >= lvl);
    if (fifo_en) begin
      // transmit count reads as zero, so the transmit level is always met
      r.intsp = r.intsp | SRC_TXD;
      if (rx_hit) begin
        r.dma_hit = 1'b1;
        r.intsp   = r.intsp | SRC_RXD;
      end
    end else if (stat0) begin
      r.dma_hit = 1'b1;
      r.intsp   = r.intsp | SRC_RXD;
    end
    r.intp = r.intsp & ~intm;
    return r;
  endfunction

endpackage

### rtl/urx_fifo.sv
// ----------------------------------------------------------------------------
// urx_fifo
// Receive byte FIFO with read/write pointers and a true occupancy count.
// ----------------------------------------------------------------------------
module urx_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  urx_pkg::urx_fifo_ctrl_t       ctrl_i,
  output logic [urx_pkg::CNT_W-1:0]     count_o,
  output logic [7:0]                    rdata_o
);

  logic [7:0]                mem [urx_pkg::RX_DEPTH];
  logic [urx_pkg::PTR_W-1:0] wptr_q, wptr_d;
  logic [urx_pkg::PTR_W-1:0] rptr_q, rptr_d;
  logic [urx_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]                rdata_q;

  localparam logic [urx_pkg::PTR_W-1:0] LAST = urx_pkg::PTR_W'(urx_pkg::RX_DEPTH - 1);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (ctrl_i.clear) begin
      wptr_d = '0;
      rptr_d = '0;
      cnt_d  = '0;
    end else if (ctrl_i.push) begin
      wptr_d = (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end else if (ctrl_i.pop) begin
      rptr_d = (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Prefetch the byte at the next read pointer; forward a push that lands there.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      mem[wptr_q] <= ctrl_i.wdata;
    end
    if (ctrl_i.push && !ctrl_i.clear && (wptr_q == rptr_d)) begin
      rdata_q <= ctrl_i.wdata;
    end else begin
      rdata_q <= mem[rptr_d];
    end
  end

  assign rdata_o = rdata_q;
  assign count_o = cnt_q;

endmodule

### rtl/urx_core.sv
// ----------------------------------------------------------------------------
// urx_core
// Register file, request decode and interrupt logic; one word per cycle while fire_i is high.
// ----------------------------------------------------------------------------
module urx_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  urx_pkg::urx_in_t              item_i,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_wdata_i,
  input  logic [urx_pkg::CNT_W-1:0]     fifo_cnt_i,
  input  logic [7:0]                    fifo_rdata_i,
  output urx_pkg::urx_fifo_ctrl_t       fifo_ctrl_o,
  output urx_pkg::urx_out_t             res_o
);

  logic [2:0]  chan_q;
  logic [31:0] ulcon_q, ulcon_d, ucon_q, ucon_d, ufcon_q, ufcon_d, umcon_q, umcon_d;
  logic [31:0] brdiv_q, brdiv_d, frac_q, frac_d, intm_q, intm_d;
  logic [7:0]  rx_q, rx_d;
  logic        stat0_q, stat0_d, stat3_q, stat3_d, err3_q, err3_d;
  logic [2:0]  intsp_q, intsp_d, intp_q, intp_d;
  logic        dma_q, dma_d;

  logic [urx_pkg::CNT_W-1:0] cnt_n;
  logic                      full;
  logic                      do_irq, do_dma;
  urx_pkg::urx_irq_t         irq;
  logic [31:0]               rdata;
  logic [31:0]               wd;

  assign full = (fifo_cnt_i == urx_pkg::CNT_W'(urx_pkg::RX_DEPTH));
  assign wd   = item_i.write_data;

  always_comb begin
    ulcon_d = ulcon_q;
    ucon_d  = ucon_q;
    ufcon_d = ufcon_q;
    umcon_d = umcon_q;
    brdiv_d = brdiv_q;
    frac_d  = frac_q;
    intm_d  = intm_q;
    rx_d    = rx_q;
    stat0_d = stat0_q;
    stat3_d = stat3_q;
    err3_d  = err3_q;
    intsp_d = intsp_q;
    intp_d  = intp_q;
    cnt_n   = fifo_cnt_i;
    do_irq  = 1'b0;
    do_dma  = 1'b0;
    rdata   = '0;
    fifo_ctrl_o   = '0;
    res_o         = '0;

    if (fire_i) begin
      case (item_i.req_type)
        urx_pkg::REQ_READ: begin
          case (item_i.reg_index)
            urx_pkg::R_ULCON: rdata = ulcon_q;
            urx_pkg::R_UCON:  rdata = ucon_q;
            urx_pkg::R_UFCON: rdata = ufcon_q;
            urx_pkg::R_UMCON: rdata = umcon_q;
            urx_pkg::R_STAT:  rdata = {28'b0, stat3_q, 2'b11, stat0_q};
            urx_pkg::R_ERR: begin
              rdata  = {28'b0, err3_q, 3'b0};
              err3_d = 1'b0;
            end
            urx_pkg::R_FSTAT: rdata = full ? urx_pkg::FSTAT_FULL : 32'(fifo_cnt_i);
            urx_pkg::R_RX: begin
              if (ufcon_q[0]) begin
                if (fifo_cnt_i != '0) begin
                  rdata           = 32'(fifo_rdata_i);
                  fifo_ctrl_o.pop = 1'b1;
                  cnt_n           = fifo_cnt_i - 1'b1;
                  stat0_d         = (cnt_n != '0);
                end else begin
                  // pop from an empty FIFO flags an error
                  intsp_d = intsp_q | urx_pkg::SRC_ERR;
                  do_irq  = 1'b1;
                end
              end else begin
                stat0_d = 1'b0;
                rdata   = 32'(rx_q);
              end
              do_dma = 1'b1;
            end
            urx_pkg::R_BRDIV: rdata = brdiv_q;
            urx_pkg::R_FRAC:  rdata = frac_q;
            urx_pkg::R_INTP:  rdata = 32'(intp_q);
            urx_pkg::R_INTSP: rdata = 32'(intsp_q);
            urx_pkg::R_INTM:  rdata = intm_q;
            default:          rdata = '0;
          endcase
        end
        urx_pkg::REQ_WRITE: begin
          case (item_i.reg_index)
            urx_pkg::R_ULCON: ulcon_d = wd;
            urx_pkg::R_UCON:  ucon_d  = wd;
            urx_pkg::R_UMCON: umcon_d = wd;
            urx_pkg::R_BRDIV: brdiv_d = wd;
            urx_pkg::R_FRAC:  frac_d  = wd;
            urx_pkg::R_UFCON: begin
              ufcon_d = wd & ~urx_pkg::UFCON_SELFCLR;
              if (wd[1]) begin
                fifo_ctrl_o.clear = 1'b1;
                cnt_n             = '0;
              end
            end
            urx_pkg::R_TX: begin
              intsp_d        = intsp_q | urx_pkg::SRC_TXD;
              do_irq         = 1'b1;
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = wd[7:0];
            end
            urx_pkg::R_INTP: begin
              intp_d  = intp_q & ~wd[2:0];
              intsp_d = intsp_q & ~wd[2:0];
              do_irq  = 1'b1;
            end
            urx_pkg::R_STAT: begin
              if (wd[3]) begin
                stat3_d = 1'b0;
              end
            end
            urx_pkg::R_INTSP: intsp_d = intsp_q & ~wd[2:0];
            urx_pkg::R_INTM: begin
              intm_d = wd;
              do_irq = 1'b1;
            end
            default: ;
          endcase
        end
        urx_pkg::REQ_RX_BYTE: begin
          if (ufcon_q[0]) begin
            if (full) begin
              // overrun: drop the byte
              intsp_d = intsp_q | urx_pkg::SRC_ERR;
            end else begin
              fifo_ctrl_o.push  = 1'b1;
              fifo_ctrl_o.wdata = item_i.rx_byte;
              cnt_n             = fifo_cnt_i + 1'b1;
            end
          end else begin
            rx_d = item_i.rx_byte;
          end
          stat0_d = 1'b1;
          do_irq  = 1'b1;
        end
        urx_pkg::REQ_BREAK: begin
          if (!full) begin
            fifo_ctrl_o.push = 1'b1;
            cnt_n            = fifo_cnt_i + 1'b1;
          end
          err3_d = 1'b1;
          do_irq = 1'b1;
        end
        urx_pkg::REQ_TIMEOUT: begin
          if (stat0_q || ucon_q[urx_pkg::UCON_TOUT_EN]) begin
            intsp_d = intsp_q | urx_pkg::SRC_RXD;
            stat3_d = 1'b1;
            do_dma  = 1'b1;
            do_irq  = 1'b1;
          end
        end
        default: ;
      endcase
    end

    irq = urx_pkg::irq_eval(ufcon_d[0], ufcon_d[6:4], chan_q,
                            ucon_d[urx_pkg::UCON_TOUT_DIS], stat0_d, cnt_n,
                            intsp_d, intm_d[2:0]);
    if (do_irq) begin
      intsp_d = irq.intsp;
      intp_d  = irq.intp;
    end

    dma_d = dma_q;
    if (do_dma || (do_irq && irq.dma_hit)) begin
      dma_d = (ucon_d[1:0] == urx_pkg::UCON_RX_DMA) && (cnt_n == '0);
    end

    res_o.read_data = rdata;
    res_o.irq_line  = |intp_d;
    res_o.dma_busy  = dma_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= '0;
      ulcon_q <= '0;
      ucon_q  <= urx_pkg::UCON_RESET;
      ufcon_q <= '0;
      umcon_q <= '0;
      brdiv_q <= '0;
      frac_q  <= '0;
      intm_q  <= '0;
      rx_q    <= '0;
      stat0_q <= 1'b0;
      stat3_q <= 1'b0;
      err3_q  <= 1'b0;
      intsp_q <= '0;
      intp_q  <= '0;
      dma_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chan_q <= cfg_wdata_i;
      end
      ulcon_q <= ulcon_d;
      ucon_q  <= ucon_d;
      ufcon_q <= ufcon_d;
      umcon_q <= umcon_d;
      brdiv_q <= brdiv_d;
      frac_q  <= frac_d;
      intm_q  <= intm_d;
      rx_q    <= rx_d;
      stat0_q <= stat0_d;
      stat3_q <= stat3_d;
      err3_q  <= err3_d;
      intsp_q <= intsp_d;
      intp_q  <= intp_d;
      dma_q   <= dma_d;
    end
  end

endmodule

### rtl/uart_regs_rx_fifo_irq.sv
// ----------------------------------------------------------------------------
// uart_regs_rx_fifo_irq
// UART register block with a 16-byte receive FIFO and interrupt logic.
// ----------------------------------------------------------------------------
// Each input word is a bus read, a bus write, a received byte, a line break
// or an expired receive timeout, and yields exactly one result word with the
// read data, any transmitted byte, the interrupt line and the receive-DMA
// busy flag. A word is held in the input register and is resolved against
// the register file and FIFO in a single pass into the result register; one
// word is accepted every cycle, and the input side stalls only while both the
// input and the result register are occupied and the result is stalled
// downstream. The user must write the channel number through cfg_we_i /
// cfg_wdata_i only while no word is in flight; the block does not enforce
// it. No clearing pass is needed after reset: the FIFO occupancy count
// guards every byte read.
// ----------------------------------------------------------------------------
module uart_regs_rx_fifo_irq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  urx_pkg::urx_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output urx_pkg::urx_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i
);

  logic                      in_vld_q, in_vld_d;
  urx_pkg::urx_in_t          in_q;
  logic                      out_vld_q, out_vld_d;
  urx_pkg::urx_out_t         out_q;
  logic                      fire, accept;
  urx_pkg::urx_out_t         res;
  urx_pkg::urx_fifo_ctrl_t   fifo_ctrl;
  logic [urx_pkg::CNT_W-1:0] fifo_cnt;
  logic [7:0]                fifo_rdata;

  // Advance the held word whenever the result register is free or draining.
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Hold payloads until the next handshake moves them.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  urx_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (in_q),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fifo_cnt_i   (fifo_cnt),
    .fifo_rdata_i (fifo_rdata),
    .fifo_ctrl_o  (fifo_ctrl),
    .res_o        (res)
  );

  urx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fifo_ctrl),
    .count_o (fifo_cnt),
    .rdata_o (fifo_rdata)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt <= urx_pkg::CNT_W'(urx_pkg::RX_DEPTH))
    else $error("receive FIFO count exceeds depth");

  a_fire_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("resolved word did not reach the result register");

  a_held_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> (in_vld_q && $stable(in_q)))
    else $error("waiting input word was lost or changed");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_ctrl.push && !fifo_ctrl.clear) |->
      (fifo_cnt != urx_pkg::CNT_W'(urx_pkg::RX_DEPTH)))
    else $error("push into a full receive FIFO");
`endif

endmodule
